// ===== hdl/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpd_pkg
// Types and constants shared by the address pair dedup table.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam logic [1:0] VERDICT_REJECT   = 2'd0;
    localparam logic [1:0] VERDICT_SUPPRESS = 2'd1;
    localparam logic [1:0] VERDICT_EMIT     = 2'd2;

    localparam logic [15:0] COOLDOWN_RESET = 16'd60;

    localparam logic [7:0] OCT_PRIV_A      = 8'd10;
    localparam logic [7:0] OCT_LOOPBACK    = 8'd127;
    localparam logic [7:0] OCT_PRIV_B      = 8'd172;
    localparam logic [7:0] OCT_PRIV_B_LO   = 8'd16;
    localparam logic [7:0] OCT_PRIV_B_HI   = 8'd31;
    localparam logic [7:0] OCT_PRIV_C      = 8'd192;
    localparam logic [7:0] OCT_PRIV_C_2ND  = 8'd168;
    localparam logic [7:0] OCT_MCAST_BASE  = 8'd224;
    localparam logic [7:0] OCT_ALL_ONES    = 8'd255;
    localparam logic [7:0] OCT_ZERO        = 8'd0;

    localparam int MAC_MCAST_BIT = 40;

    typedef struct packed {
        logic [31:0] address_ip;
        logic [47:0] station_mac;
        logic        source_kind;
        logic [31:0] time_seconds;
    } t_obs;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] out_ip;
        logic [47:0] out_mac;
        logic        out_source;
        logic [31:0] out_time;
    } t_res;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] seen_time;
    } t_entry;

endpackage

// ===== hdl/tpd_if.sv =====
// ----------------------------------------------------------------------------
// tpd_if
// Valid/ready channels for observation words and result words.
// ----------------------------------------------------------------------------
interface tpd_obs_if;
    logic          valid;
    logic          ready;
    tpd_pkg::t_obs data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpd_res_if;
    logic          valid;
    logic          ready;
    tpd_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tpd_addr_filter.sv =====
// ----------------------------------------------------------------------------
// tpd_addr_filter
// Passes unicast private IPv4 addresses with a non-multicast MAC.
// ----------------------------------------------------------------------------
module tpd_addr_filter (
    input  logic [31:0] i_ip,
    input  logic [47:0] i_mac,
    output logic        o_pass
);

    logic [7:0] w_o1;
    logic [7:0] w_o2;
    logic [7:0] w_o4;
    logic       w_bad;
    logic       w_priv;

    assign w_o1 = i_ip[31:24];
    assign w_o2 = i_ip[23:16];
    assign w_o4 = i_ip[7:0];

    assign w_bad = (i_ip == 32'd0) || (i_ip == 32'hFFFF_FFFF)
                || (w_o1 == tpd_pkg::OCT_LOOPBACK) || (w_o1 >= tpd_pkg::OCT_MCAST_BASE)
                || (w_o4 == tpd_pkg::OCT_ZERO) || (w_o4 == tpd_pkg::OCT_ALL_ONES)
                || i_mac[tpd_pkg::MAC_MCAST_BIT];

    assign w_priv = (w_o1 == tpd_pkg::OCT_PRIV_A)
                 || ((w_o1 == tpd_pkg::OCT_PRIV_B) && (w_o2 >= tpd_pkg::OCT_PRIV_B_LO)
                     && (w_o2 <= tpd_pkg::OCT_PRIV_B_HI))
                 || ((w_o1 == tpd_pkg::OCT_PRIV_C) && (w_o2 == tpd_pkg::OCT_PRIV_C_2ND));

    assign o_pass = !w_bad && w_priv;

endmodule

// ===== hdl/tpd_entry_ram.sv =====
// ----------------------------------------------------------------------------
// tpd_entry_ram
// Simple dual-port entry store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tpd_entry_ram #(
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  tpd_pkg::t_entry    i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output tpd_pkg::t_entry    o_rdata
);

    tpd_pkg::t_entry r_mem [DEPTH];
    tpd_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/timed_pair_dedup_table.sv =====
// ----------------------------------------------------------------------------
// timed_pair_dedup_table
// Address filter and cooldown table of (ip, mac, last seen) entries.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake           | word
//  i_obs     | in  | valid/ready         | address_ip, station_mac, source_kind, time_seconds
//  o_res     | out | valid/ready         | verdict, out_ip, out_mac, out_source, out_time
//  i_cfg_*   | in  | write enable        | cooldown_seconds
//
//  One word at a time. A rejected word skips the table; a passing word is
//  checked by a scan of the filled entries through the single RAM read port,
//  one entry per cycle, up to TABLE_ENTRIES entries.
//  Entries fill from index 0 upwards and are never freed, so a fill count
//  stands in for the valid marks; reset clears it at once, no clearing pass.
//  A result waits in the output register while o_res.ready is low; the next
//  word is taken once the previous result has been loaded there.
// ----------------------------------------------------------------------------
module timed_pair_dedup_table #(
    parameter int TABLE_ENTRIES = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tpd_obs_if.sink          i_obs,
    tpd_res_if.source        o_res,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_DONE
    } t_state;

    t_state          r_state,    n_state;
    tpd_pkg::t_obs   r_obs,      n_obs;
    logic [CW-1:0]   r_issue,    n_issue;
    logic            r_pend,     n_pend;
    logic [CW-1:0]   r_pend_idx, n_pend_idx;
    logic [31:0]     r_old_time, n_old_time;
    logic [AW-1:0]   r_old_idx,  n_old_idx;
    logic [31:0]     r_hit_time, n_hit_time;
    logic [AW-1:0]   r_hit_idx,  n_hit_idx;
    logic [CW-1:0]   r_count,    n_count;
    logic [1:0]      r_verdict,  n_verdict;
    logic [15:0]     r_cooldown, n_cooldown;
    logic            r_out_valid, n_out_valid;
    tpd_pkg::t_res   r_out,      n_out;

    logic            w_pass;
    logic            w_hit;
    logic            w_last;
    logic            w_full;
    logic [31:0]     w_diff;
    logic            w_within;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    tpd_pkg::t_entry ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    tpd_pkg::t_entry ram_rdata;

    tpd_addr_filter u_filter (
        .i_ip   (i_obs.data.address_ip),
        .i_mac  (i_obs.data.station_mac),
        .o_pass (w_pass)
    );

    tpd_entry_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_obs.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_hit    = (ram_rdata.ip == r_obs.address_ip) && (ram_rdata.mac == r_obs.station_mac);
    assign w_last   = (CW'(r_pend_idx + CW'(1)) == r_count);
    assign w_full   = (r_count == CW'(TABLE_ENTRIES));
    assign w_diff   = r_obs.time_seconds - r_hit_time;
    assign w_within = w_diff[31] || (w_diff < {16'd0, r_cooldown});

    always_comb begin
        n_state     = r_state;
        n_obs       = r_obs;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_pend_idx  = r_issue;
        n_old_time  = r_old_time;
        n_old_idx   = r_old_idx;
        n_hit_time  = r_hit_time;
        n_hit_idx   = r_hit_idx;
        n_count     = r_count;
        n_verdict   = r_verdict;
        n_cooldown  = r_cooldown;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_hit_idx;
        ram_wdata   = '{ip: r_obs.address_ip, mac: r_obs.station_mac,
                        seen_time: r_obs.time_seconds};
        ram_re      = 1'b0;
        ram_raddr   = r_issue[AW-1:0];

        if (i_cfg_we) begin
            n_cooldown = i_cfg_data;
        end

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_obs.valid) begin
                    n_obs   = i_obs.data;
                    n_issue = '0;
                    if (!w_pass) begin
                        n_verdict = tpd_pkg::VERDICT_REJECT;
                        n_state   = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ram_re  = (r_issue < r_count);
                n_issue = r_issue + CW'(ram_re);
                n_pend  = ram_re;
                if (r_pend) begin
                    if (w_hit) begin
                        n_hit_time = ram_rdata.seen_time;
                        n_hit_idx  = r_pend_idx[AW-1:0];
                        n_state    = S_HIT;
                    end else begin
                        if ((r_pend_idx == '0) || (ram_rdata.seen_time < r_old_time)) begin
                            n_old_time = ram_rdata.seen_time;
                            n_old_idx  = r_pend_idx[AW-1:0];
                        end
                        if (w_last) begin
                            n_state = S_MISS;
                        end
                    end
                end
            end
            S_HIT: begin
                if (w_within) begin
                    n_verdict = tpd_pkg::VERDICT_SUPPRESS;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_hit_idx;
                    n_verdict = tpd_pkg::VERDICT_EMIT;
                end
                n_state = S_DONE;
            end
            S_MISS: begin
                ram_we = 1'b1;
                if (w_full) begin
                    ram_waddr = r_old_idx;
                end else begin
                    ram_waddr = r_count[AW-1:0];
                    n_count   = r_count + CW'(1);
                end
                n_verdict = tpd_pkg::VERDICT_EMIT;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '{verdict: r_verdict, out_ip: r_obs.address_ip,
                                   out_mac: r_obs.station_mac, out_source: r_obs.source_kind,
                                   out_time: r_obs.time_seconds};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_cooldown  <= tpd_pkg::COOLDOWN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_cooldown  <= n_cooldown;
            r_out_valid <= n_out_valid;
            r_obs       <= n_obs;
            r_issue     <= n_issue;
            r_pend_idx  <= n_pend_idx;
            r_old_time  <= n_old_time;
            r_old_idx   <= n_old_idx;
            r_hit_time  <= n_hit_time;
            r_hit_idx   <= n_hit_idx;
            r_verdict   <= n_verdict;
            r_out       <= n_out;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("fill count beyond table depth");

    a_fill_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MISS) && !w_full |=> r_count == CW'($past(r_count) + CW'(1)))
        else $error("fill count did not advance on new entry");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_obs.valid && i_obs.ready |=> r_state != S_IDLE)
        else $error("accepted word did not start processing");

    a_suppress_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIT) && w_within |-> !ram_we)
        else $error("table written on suppressed word");

endmodule
